// ===== design/wre_pkg.sv =====
// ----------------------------------------------------------------------------
// wre_pkg
// Shared constants, codes and types for the windowed rate eta estimator.
// ----------------------------------------------------------------------------
package wre_pkg;

    // default sizing
    localparam int DEF_WINDOW   = 30;
    localparam int DEF_CHANNELS = 8;

    // item field widths
    localparam int ACT_W  = 2;
    localparam int CH_W   = 3;
    localparam int RATE_W = 31;
    localparam int REM_W  = 48;
    localparam int ETA_W  = 53;
    localparam int HELD_W = 5;

    // stream bus widths
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 64;

    // item kinds carried on s_tuser
    typedef enum logic [ACT_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_META,
        ST_SAMP,
        ST_START,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== design/wre_sample_mem.sv =====
// ----------------------------------------------------------------------------
// wre_sample_mem
// Ring storage for all channels' rate samples, one synchronous read port and
// one write port, read data registered.
// ----------------------------------------------------------------------------
module wre_sample_mem #(
    parameter int DEPTH = wre_pkg::DEF_CHANNELS * wre_pkg::DEF_WINDOW,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [wre_pkg::RATE_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [wre_pkg::RATE_W-1:0] wr_data
);

    logic [wre_pkg::RATE_W-1:0] mem [DEPTH];
    logic [wre_pkg::RATE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/wre_meta_mem.sv =====
// ----------------------------------------------------------------------------
// wre_meta_mem
// Per channel window state {sum, count, slot} in a synchronous memory, with
// one valid bit per channel so reset and clear read back as all zero.
// ----------------------------------------------------------------------------
module wre_meta_mem #(
    parameter int CHANNELS = wre_pkg::DEF_CHANNELS,
    parameter int MTW      = 46,
    parameter int MW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rd_en,
    input  logic [MW-1:0]  rd_addr,
    output logic [MTW-1:0] rd_data,
    input  logic           wr_en,
    input  logic [MW-1:0]  wr_addr,
    input  logic [MTW-1:0] wr_data,
    input  logic           clr_en,
    input  logic [MW-1:0]  clr_addr
);

    logic [MTW-1:0]      mem [CHANNELS];
    logic [MTW-1:0]      rd_word_reg;
    logic                rd_vld_reg;
    logic [CHANNELS-1:0] vld_reg;
    logic [CHANNELS-1:0] vld_next;

    // valid bits: set by a write, dropped by a clear
    always_comb
    begin
        vld_next = vld_reg;
        if (wr_en)
        begin
            vld_next[wr_addr] = 1'b1;
        end
        if (clr_en)
        begin
            vld_next[clr_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (rd_en)
            begin
                rd_vld_reg <= (int'(rd_addr) < CHANNELS) && vld_reg[rd_addr];
            end
        end
    end

    // data array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // an entry never written since reset or clear reads as zero
    assign rd_data = rd_vld_reg ? rd_word_reg : '0;

endmodule

// ===== design/wre_divider.sv =====
// ----------------------------------------------------------------------------
// wre_divider
// Restoring radix-2 divider, one quotient bit per cycle, done pulse when the
// quotient is complete.
// ----------------------------------------------------------------------------
module wre_divider #(
    parameter int NW = wre_pkg::REM_W + 5,
    parameter int DW = wre_pkg::RATE_W + 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    output logic          done,
    output logic [NW-1:0] quot
);

    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   dvs_reg, dvs_next;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            ge;

    // one trial subtraction per step
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(NW);
            rem_next  = '0;
            quo_next  = numer;
            dvs_next  = denom;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ===== design/windowed_rate_eta_estimator.sv =====
// ----------------------------------------------------------------------------
// windowed_rate_eta_estimator
// Per channel moving window of rate samples with an exact integer time left
// estimate, floor(remaining * count / sum).
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_ stream; s_tuser carries the kind (add sample, clear
//   channel, query, no-op) and s_tdata the channel, sample rate, remaining
//   bytes and inactive flag. Every item gives exactly one result item on the
//   m_ stream: eta in m_tdata with the samples held, eta_valid on m_tuser.
//   Items are worked one at a time. Window state sits in a per channel
//   memory, samples in a ring memory; both have registered read data.
//   Each item first reads its window state. Clear, no-op or an invalid
//   query then go straight to the result, an add also reads and writes the
//   sample ring, and a valid query also runs the one bit per cycle divider.
//   s_tready is high again the cycle after a result is loaded, even while
//   that result still waits in the output register.
//   When the receiver stalls, the result holds on m_tdata/m_tuser and the
//   next item is worked but waits before loading until the output is free.
//   Reset empties every channel at once through per channel valid bits;
//   no clearing pass is needed and items are taken right after reset.
// ----------------------------------------------------------------------------
module windowed_rate_eta_estimator #(
    parameter int WINDOW   = wre_pkg::DEF_WINDOW,
    parameter int CHANNELS = wre_pkg::DEF_CHANNELS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // channel[2:0], sample_rate[33:3], remaining_bytes[81:34], inactive[82]
    input  logic [wre_pkg::S_TDATA_W-1:0] s_tdata,
    // action[1:0]
    input  logic [wre_pkg::ACT_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // eta_seconds[52:0], samples_held[57:53]
    output logic [wre_pkg::M_TDATA_W-1:0] m_tdata,
    // eta_valid[0]
    output logic                          m_tuser
);

    localparam int SW    = wre_pkg::RATE_W + $clog2(WINDOW);
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int SLW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = wre_pkg::REM_W + CW;
    localparam int MTW   = SW + CW + SLW;

    localparam int CH_LO   = 0;
    localparam int RATE_LO = CH_LO + wre_pkg::CH_W;
    localparam int REM_LO  = RATE_LO + wre_pkg::RATE_W;
    localparam int INACT_B = REM_LO + wre_pkg::REM_W;
    localparam int OUT_PAD = wre_pkg::M_TDATA_W - wre_pkg::ETA_W - wre_pkg::HELD_W;

    // input field slices
    logic [wre_pkg::CH_W-1:0]   ch_in;
    logic [wre_pkg::RATE_W-1:0] rate_in;
    logic [wre_pkg::REM_W-1:0]  rem_in;
    logic                       inact_in;
    logic                       accept;

    assign ch_in    = s_tdata[RATE_LO-1:CH_LO];
    assign rate_in  = s_tdata[REM_LO-1:RATE_LO];
    assign rem_in   = s_tdata[INACT_B-1:REM_LO];
    assign inact_in = s_tdata[INACT_B];

    // control state
    wre_pkg::state_t state_reg, state_next;
    logic            chan_ok_reg;
    logic            m_tvalid_reg, m_tvalid_next;

    // item payload
    wre_pkg::action_t           act_reg;
    logic [wre_pkg::CH_W-1:0]   ch_reg;
    logic [wre_pkg::RATE_W-1:0] rate_reg;
    logic [wre_pkg::REM_W-1:0]  rembytes_reg;
    logic                       inact_reg;

    // working registers
    logic [SW-1:0]  sum_reg, sum_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [SLW-1:0] slot_reg, slot_next;
    logic [AW-1:0]  saddr_reg, saddr_next;
    logic [NW-1:0]  numer_reg, numer_next;

    // result staging and output registers
    logic [wre_pkg::ETA_W-1:0]  res_eta_reg, res_eta_next;
    logic                       res_vld_reg, res_vld_next;
    logic [CW-1:0]              res_held_reg, res_held_next;
    logic [wre_pkg::ETA_W-1:0]  out_eta_reg, out_eta_next;
    logic                       out_vld_reg, out_vld_next;
    logic [wre_pkg::HELD_W-1:0] out_held_reg, out_held_next;

    // memory and divider hookup
    logic [MTW-1:0]             meta_rdata;
    logic [MTW-1:0]             meta_wdata;
    logic                       meta_we;
    logic                       meta_clr;
    logic [MW-1:0]              meta_addr;
    logic [wre_pkg::RATE_W-1:0] samp_rdata;
    logic                       samp_re;
    logic                       samp_we;
    logic                       div_start;
    logic                       div_done;
    logic [NW-1:0]              div_quot;

    // unpacked window state and helpers
    logic [SW-1:0]                  cur_sum;
    logic [CW-1:0]                  cur_cnt;
    logic [SLW-1:0]                 cur_slot;
    logic [SLW-1:0]                 slot_eff;
    logic [SW-1:0]                  new_sum;
    logic [CW-1:0]                  new_cnt;
    logic [SLW-1:0]                 new_slot;
    logic                           out_free;
    logic [NW+wre_pkg::ETA_W-1:0]   quot_wide;
    logic [wre_pkg::ETA_W-1:0]      eta_sat;
    logic [CW+wre_pkg::HELD_W-1:0]  held_wide;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == wre_pkg::ST_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign meta_addr = accept ? MW'(ch_in) : MW'(ch_reg);

    assign {cur_sum, cur_cnt, cur_slot} = meta_rdata;
    assign slot_eff = (int'(cur_slot) >= WINDOW) ? '0 : cur_slot;

    // ring update from the old sample
    always_comb
    begin
        if (int'(cnt_reg) >= WINDOW)
        begin
            new_sum = sum_reg - SW'(samp_rdata) + SW'(rate_reg);
            new_cnt = cnt_reg;
        end
        else
        begin
            new_sum = sum_reg + SW'(rate_reg);
            new_cnt = cnt_reg + CW'(1);
        end
        if (int'(slot_reg) + 1 >= WINDOW)
        begin
            new_slot = '0;
        end
        else
        begin
            new_slot = slot_reg + SLW'(1);
        end
    end

    assign meta_wdata = {new_sum, new_cnt, new_slot};

    // quotient saturation to the eta width
    assign quot_wide = {{wre_pkg::ETA_W{1'b0}}, div_quot};
    assign eta_sat   = (|quot_wide[NW+wre_pkg::ETA_W-1:wre_pkg::ETA_W]) ? '1 :
                       quot_wide[wre_pkg::ETA_W-1:0];

    // held count masked to the port width
    assign held_wide = {{wre_pkg::HELD_W{1'b0}}, res_held_reg};

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        slot_next     = slot_reg;
        saddr_next    = saddr_reg;
        numer_next    = numer_reg;
        res_eta_next  = res_eta_reg;
        res_vld_next  = res_vld_reg;
        res_held_next = res_held_reg;
        out_eta_next  = out_eta_reg;
        out_vld_next  = out_vld_reg;
        out_held_next = out_held_reg;
        m_tvalid_next = m_tvalid_reg;
        meta_we       = 1'b0;
        meta_clr      = 1'b0;
        samp_re       = 1'b0;
        samp_we       = 1'b0;
        div_start     = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            wre_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = wre_pkg::ST_META;
                end
            end

            wre_pkg::ST_META:
            begin
                sum_next      = cur_sum;
                cnt_next      = cur_cnt;
                slot_next     = slot_eff;
                saddr_next    = AW'(int'(ch_reg) * WINDOW + int'(slot_eff));
                numer_next    = NW'(rembytes_reg) * NW'(cur_cnt);
                res_eta_next  = '0;
                res_vld_next  = 1'b0;
                res_held_next = cur_cnt;
                state_next    = wre_pkg::ST_DONE;
                if (!chan_ok_reg)
                begin
                    res_held_next = '0;
                end
                else
                begin
                    unique case (act_reg)
                        wre_pkg::ACT_ADD:
                        begin
                            samp_re    = 1'b1;
                            state_next = wre_pkg::ST_SAMP;
                        end
                        wre_pkg::ACT_CLEAR:
                        begin
                            meta_clr      = 1'b1;
                            res_held_next = '0;
                        end
                        wre_pkg::ACT_QUERY:
                        begin
                            if (!inact_reg && cur_cnt != '0 && cur_sum != '0)
                            begin
                                state_next = wre_pkg::ST_START;
                            end
                        end
                        wre_pkg::ACT_NOP:
                        begin
                            res_held_next = cur_cnt;
                        end
                    endcase
                end
            end

            wre_pkg::ST_SAMP:
            begin
                meta_we       = 1'b1;
                samp_we       = 1'b1;
                res_held_next = new_cnt;
                state_next    = wre_pkg::ST_DONE;
            end

            wre_pkg::ST_START:
            begin
                div_start  = 1'b1;
                state_next = wre_pkg::ST_DIV;
            end

            wre_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    res_eta_next = eta_sat;
                    res_vld_next = 1'b1;
                    state_next   = wre_pkg::ST_DONE;
                end
            end

            wre_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_eta_next  = res_eta_reg;
                    out_vld_next  = res_vld_reg;
                    out_held_next = held_wide[wre_pkg::HELD_W-1:0];
                    m_tvalid_next = 1'b1;
                    state_next    = wre_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = wre_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= wre_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            chan_ok_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (accept)
            begin
                chan_ok_reg <= (int'(ch_in) < CHANNELS);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg      <= wre_pkg::action_t'(s_tuser);
            ch_reg       <= ch_in;
            rate_reg     <= rate_in;
            rembytes_reg <= rem_in;
            inact_reg    <= inact_in;
        end
        sum_reg      <= sum_next;
        cnt_reg      <= cnt_next;
        slot_reg     <= slot_next;
        saddr_reg    <= saddr_next;
        numer_reg    <= numer_next;
        res_eta_reg  <= res_eta_next;
        res_vld_reg  <= res_vld_next;
        res_held_reg <= res_held_next;
        out_eta_reg  <= out_eta_next;
        out_vld_reg  <= out_vld_next;
        out_held_reg <= out_held_next;
    end

    // per channel window state
    wre_meta_mem #(
        .CHANNELS (CHANNELS),
        .MTW      (MTW),
        .MW       (MW)
    ) u_meta (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (meta_addr),
        .rd_data  (meta_rdata),
        .wr_en    (meta_we),
        .wr_addr  (meta_addr),
        .wr_data  (meta_wdata),
        .clr_en   (meta_clr),
        .clr_addr (meta_addr)
    );

    // sample rings
    wre_sample_mem #(
        .DEPTH   (DEPTH),
        .AW      (AW)
    ) u_samp (
        .clk     (clk),
        .rd_en   (samp_re),
        .rd_addr (saddr_next),
        .rd_data (samp_rdata),
        .wr_en   (samp_we),
        .wr_addr (saddr_reg),
        .wr_data (rate_reg)
    );

    // time left divider
    wre_divider #(
        .NW    (NW),
        .DW    (SW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (numer_reg),
        .denom (sum_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // output ports
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, out_held_reg, out_eta_reg};
    assign m_tuser  = out_vld_reg;

    // checks
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == wre_pkg::ST_DIV)
        else $error("divider finished outside the divide state");

    a_invalid_eta_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[wre_pkg::ETA_W-1:0] == '0)
        else $error("nonzero eta on an invalid result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        meta_we |-> int'(new_cnt) <= WINDOW)
        else $error("window count beyond window length");

    a_accept_reads_meta: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == wre_pkg::ST_META)
        else $error("accepted item did not start a state read");

endmodule

// ===== bench/windowed_rate_eta_estimator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_rate_eta_estimator_tb
// Self-checking bench for the per channel rate window and time left estimate.
// A directed sequence covers the empty, inactive and zero sum queries, no-ops
// and a full ring that wraps. Random traffic then runs through several phases
// of sender gaps and receiver stalls, plus one long output hold-off. Each
// accepted item runs through a local window model, and every result item is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module windowed_rate_eta_estimator_tb;

    localparam int WINDOW      = wre_pkg::DEF_WINDOW;
    localparam int CHANNELS    = wre_pkg::DEF_CHANNELS;
    localparam int ACT_W       = wre_pkg::ACT_W;
    localparam int CH_W        = wre_pkg::CH_W;
    localparam int RATE_W      = wre_pkg::RATE_W;
    localparam int REM_W       = wre_pkg::REM_W;
    localparam int ETA_W       = wre_pkg::ETA_W;
    localparam int HELD_W      = wre_pkg::HELD_W;
    localparam int S_TDATA_W   = wre_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = wre_pkg::M_TDATA_W;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 80;
    localparam longint unsigned ETA_MAX  = (64'd1 << ETA_W) - 1;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;
    localparam logic [REM_W-1:0]  REM_MAX  = '1;

    // one input item, typed
    typedef struct {
        wre_pkg::action_t    act;
        logic [CH_W-1:0]     ch;
        logic [RATE_W-1:0]   rate;
        logic [REM_W-1:0]    rem;
        logic                inactive;
    } wre_item_t;

    // one result item
    typedef struct {
        logic [ETA_W-1:0]    eta;
        logic                valid;
        logic [HELD_W-1:0]   held;
    } eta_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [ACT_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // window model state
    logic [RATE_W-1:0]    ring [CHANNELS][WINDOW];
    logic [35:0]          rate_sum [CHANNELS];
    logic [HELD_W-1:0]    held_cnt [CHANNELS];
    logic [4:0]           next_slot [CHANNELS];

    eta_result_t          eta_expected[$];
    int                   mismatch_count;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   hold_req;

    windowed_rate_eta_estimator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // advance the window model by one item and return the expected result
    function automatic eta_result_t window_eta_predict(input wre_item_t it);
        eta_result_t     res;
        logic [4:0]      slot;
        longint unsigned product;
        longint unsigned quotient;
        res.eta   = '0;
        res.valid = 1'b0;
        case (it.act)
            wre_pkg::ACT_ADD:
            begin
                slot = next_slot[it.ch];
                if (slot >= WINDOW)
                    slot = '0;
                // full ring drops the oldest sample
                if (held_cnt[it.ch] >= WINDOW)
                    rate_sum[it.ch] = rate_sum[it.ch] - 36'(ring[it.ch][slot]);
                else
                    held_cnt[it.ch] = held_cnt[it.ch] + HELD_W'(1);
                ring[it.ch][slot] = it.rate;
                rate_sum[it.ch] = rate_sum[it.ch] + 36'(it.rate);
                next_slot[it.ch] = (slot + 1 >= WINDOW) ? 5'd0 : 5'(slot + 1);
            end
            wre_pkg::ACT_CLEAR:
            begin
                rate_sum[it.ch]  = '0;
                held_cnt[it.ch]  = '0;
                next_slot[it.ch] = '0;
            end
            wre_pkg::ACT_QUERY:
            begin
                if (!it.inactive && held_cnt[it.ch] != 0 && rate_sum[it.ch] != 0)
                begin
                    product  = 64'(it.rem) * 64'(held_cnt[it.ch]);
                    quotient = product / 64'(rate_sum[it.ch]);
                    res.eta   = (quotient > ETA_MAX) ? ETA_MAX[ETA_W-1:0]
                                                     : quotient[ETA_W-1:0];
                    res.valid = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.held = held_cnt[it.ch];
        return res;
    endfunction

    function automatic wre_item_t make_item(input wre_pkg::action_t act, input int ch,
                                            input logic [RATE_W-1:0] rate,
                                            input logic [REM_W-1:0] rem,
                                            input logic inactive);
        wre_item_t it;
        it.act      = act;
        it.ch       = CH_W'(ch);
        it.rate     = rate;
        it.rem      = rem;
        it.inactive = inactive;
        return it;
    endfunction

    // random item, mostly adds and queries so windows fill and wrap
    function automatic wre_item_t random_item();
        wre_item_t it;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 55)
            it.act = wre_pkg::ACT_ADD;
        else if (pick < 90)
            it.act = wre_pkg::ACT_QUERY;
        else if (pick < 93)
            it.act = wre_pkg::ACT_CLEAR;
        else
            it.act = wre_pkg::ACT_NOP;
        it.ch = CH_W'($urandom_range(CHANNELS - 1));
        pick = $urandom_range(99);
        if (pick < 5)
            it.rate = '0;
        else if (pick < 10)
            it.rate = RATE_MAX;
        else if (pick < 40)
            it.rate = RATE_W'($urandom_range(1000));
        else
            it.rate = RATE_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 5)
            it.rem = '0;
        else if (pick < 10)
            it.rem = REM_MAX;
        else if (pick < 40)
            it.rem = REM_W'($urandom_range(100000));
        else
            it.rem = REM_W'({$urandom, $urandom});
        it.inactive = ($urandom_range(9) == 0);
        return it;
    endfunction

    // offer one item after optional gaps and wait for its handshake
    task automatic send_item(input wre_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'({$urandom, $urandom, $urandom});
            s_tuser  <= ACT_W'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, it.inactive, it.rem, it.rate, it.ch};
        s_tuser  <= it.act;
        do
            @(posedge clk);
        while (!s_tready);
        eta_expected.push_back(window_eta_predict(it));
    endtask

    // extremes of the fields, every kind and every invalid query case
    task automatic test_directed();
        send_item(make_item(wre_pkg::ACT_QUERY, 0, '0, REM_MAX, 1'b0));   // empty window
        send_item(make_item(wre_pkg::ACT_CLEAR, 7, RATE_MAX, REM_MAX, 1'b1));
        send_item(make_item(wre_pkg::ACT_NOP, 3, RATE_MAX, REM_MAX, 1'b1));
        send_item(make_item(wre_pkg::ACT_ADD, 0, RATE_MAX, '0, 1'b0));
        send_item(make_item(wre_pkg::ACT_QUERY, 0, '0, REM_MAX, 1'b0));
        send_item(make_item(wre_pkg::ACT_QUERY, 0, RATE_MAX, REM_MAX, 1'b1)); // inactive
        send_item(make_item(wre_pkg::ACT_ADD, 1, '0, REM_MAX, 1'b1));
        send_item(make_item(wre_pkg::ACT_QUERY, 1, '0, REM_MAX, 1'b0));   // zero sum
        send_item(make_item(wre_pkg::ACT_ADD, 2, RATE_W'(1), '0, 1'b0));
        send_item(make_item(wre_pkg::ACT_QUERY, 2, '0, REM_MAX, 1'b0));   // largest eta
        send_item(make_item(wre_pkg::ACT_QUERY, 2, '0, '0, 1'b0));        // valid zero eta
        send_item(make_item(wre_pkg::ACT_NOP, 2, '0, '0, 1'b0));
        send_item(make_item(wre_pkg::ACT_CLEAR, 0, '0, '0, 1'b0));
        send_item(make_item(wre_pkg::ACT_QUERY, 0, '0, REM_MAX, 1'b0));   // after clear
        send_item(make_item(wre_pkg::ACT_ADD, 7, RATE_W'(12345), '0, 1'b0));
        send_item(make_item(wre_pkg::ACT_QUERY, 7, '0, REM_W'(999999), 1'b0));
    endtask

    // fill one ring to the top, then wrap it so old samples drop out
    task automatic test_window_wrap();
        for (int i = 0; i < WINDOW; i++)
            send_item(make_item(wre_pkg::ACT_ADD, 5, RATE_MAX, '0, 1'b0));
        send_item(make_item(wre_pkg::ACT_QUERY, 5, '0, REM_MAX, 1'b0));
        for (int i = 0; i < 5; i++)
            send_item(make_item(wre_pkg::ACT_ADD, 5, RATE_W'($urandom_range(50)), '0,
                                1'b0));
        send_item(make_item(wre_pkg::ACT_QUERY, 5, '0, REM_MAX, 1'b0));
    endtask

    task automatic test_random_traffic(input int n_items, input int s_pct,
                                       input int r_pct);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        for (int i = 0; i < n_items; i++)
            send_item(random_item());
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_output_holdoff();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = hold_req + 1;
        for (int i = 0; i < 12; i++)
            send_item(random_item());
    endtask

    // receiver ready, random stalls plus the long hold-off
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        eta_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (eta_expected.size() == 0)
            begin
                $display("%0t ERROR unexpected result: expected none, %s %0d %0d %0d",
                         $time, "actual eta, valid, held", m_tdata[ETA_W-1:0], m_tuser,
                         m_tdata[ETA_W +: HELD_W]);
                mismatch_count++;
            end
            else
            begin
                exp_res = eta_expected.pop_front();
                if (m_tdata[ETA_W-1:0] !== exp_res.eta)
                begin
                    $display("%0t ERROR eta_seconds: expected %0d actual %0d",
                             $time, exp_res.eta, m_tdata[ETA_W-1:0]);
                    mismatch_count++;
                end
                if (m_tuser !== exp_res.valid)
                begin
                    $display("%0t ERROR eta_valid: expected %0d actual %0d",
                             $time, exp_res.valid, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[ETA_W +: HELD_W] !== exp_res.held)
                begin
                    $display("%0t ERROR samples_held: expected %0d actual %0d",
                             $time, exp_res.held, m_tdata[ETA_W +: HELD_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            rate_sum[c]  = '0;
            held_cnt[c]  = '0;
            next_slot[c] = '0;
            for (int s = 0; s < WINDOW; s++)
                ring[c][s] = '0;
        end
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= wre_pkg::ACT_NOP;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_window_wrap();
        test_random_traffic(310, 0, 0);
        test_random_traffic(310, 59, 0);
        test_output_holdoff();
        test_random_traffic(310, 0, 59);
        test_random_traffic(310, 20, 20);
        s_tvalid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (eta_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/wre_pkg.sv
design/wre_sample_mem.sv
design/wre_meta_mem.sv
design/wre_divider.sv
design/windowed_rate_eta_estimator.sv
bench/windowed_rate_eta_estimator_tb.sv
